// ===== sv/cdq_pkg.sv =====
// cdq_pkg: shared types and codes for the card deque
// no dependencies; used by cdq_store, the top level and the checker
package cdq_pkg;

    localparam int RANK_W      = 4;
    localparam int SUIT_W      = 2;
    localparam int SUIT_CODES  = 4;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_PUSH   = 2'd1,
        OP_POP    = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [SUIT_W-1:0] suit;
    } card_t;

endpackage

// ===== sv/cdq_slot.sv =====
// cdq_slot: circular slot address, front position plus offset wrapped at the capacity
// depends on nothing but its parameters
module cdq_slot #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic [AW-1:0] base,
    input  logic [CW-1:0] offset,
    output logic [AW-1:0] slot
);

    logic [CW:0] sum;
    logic [CW:0] wrapped;

    assign sum     = (CW+1)'(base) + (CW+1)'(offset);
    assign wrapped = (sum >= (CW+1)'(CAPACITY)) ? sum - (CW+1)'(CAPACITY) : sum;
    assign slot    = wrapped[AW-1:0];

endmodule

// ===== sv/cdq_store.sv =====
// cdq_store: card memory, one write port and one registered read port
// depends on cdq_pkg for the card type
module cdq_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic           aclk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  cdq_pkg::card_t wdata,
    input  logic [AW-1:0]  raddr,
    output cdq_pkg::card_t rdata
);

    cdq_pkg::card_t mem [DEPTH];
    cdq_pkg::card_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/card_deque_with_suit_counts.sv =====
// card_deque_with_suit_counts: card deque with remove by key and per-suit counts
// depends on cdq_pkg, cdq_slot and cdq_store
// append, push and pop on empty: EXEC, then RESP; other pops: EXEC, POPRD, RESP
// remove: EXEC, then SCAN reads the held cards from the front, on a hit SHIFT moves later cards forward, then RESP
// one item at a time; s_tready is low from the accepting edge until the result is registered
// synchronous active-low reset clears front, length and counts; the store is not cleared
module card_deque_with_suit_counts #(
    parameter int CAPACITY   = 64,
    parameter int SUIT_KINDS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // card_rank, card_suit
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // popped_rank, drawn_suit, deck_length, suit0..suit3_count
    output logic [1:0]  m_tuser    // status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int OW = cdq_pkg::COUNT_OUT_W;
    localparam int NS = cdq_pkg::SUIT_CODES;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_POPRD = 6'b000100,
        S_SCAN  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    cdq_pkg::op_t     op_reg, op_next;
    cdq_pkg::card_t   card_reg, card_next;
    cdq_pkg::card_t   pcard_reg, pcard_next;
    cdq_pkg::status_t status_reg, status_next;
    logic [AW-1:0]    front_reg, front_next;
    logic [CW-1:0]    held_reg, held_next;
    logic [CW-1:0]    cnt_reg [NS];
    logic [CW-1:0]    cnt_next [NS];
    logic [CW-1:0]    off_reg, off_next;
    logic             rv_reg, rv_next;
    logic [AW-1:0]    ra_reg, ra_next;
    logic [AW-1:0]    dst_reg, dst_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [47:0]      m_tdata_reg, m_tdata_next;
    logic [1:0]       m_tuser_reg, m_tuser_next;

    logic             issue;
    logic             cnt_up, cnt_dn;
    logic [1:0]       cnt_suit;
    logic [AW-1:0]    slot_addr;
    logic [AW-1:0]    front_dec;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    cdq_pkg::card_t   mem_wdata;
    cdq_pkg::card_t   mem_rdata;
    logic [OW-1:0]    len_out;
    logic [OW-1:0]    cnt_out [NS];

    cdq_slot #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_cdq_slot (
        .base   (front_reg),
        .offset (off_reg),
        .slot   (slot_addr)
    );

    cdq_store #(.DEPTH(CAPACITY), .AW(AW)) u_cdq_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (slot_addr),
        .rdata (mem_rdata)
    );

    assign front_dec = (front_reg == '0) ? AW'(CAPACITY - 1) : front_reg - AW'(1);
    assign len_out   = OW'(held_reg);

    always_comb begin
        for (int j = 0; j < NS; j++) begin
            cnt_out[j] = OW'(cnt_reg[j]);
        end
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        card_next     = card_reg;
        pcard_next    = pcard_reg;
        status_next   = status_reg;
        front_next    = front_reg;
        held_next     = held_reg;
        off_next      = off_reg;
        rv_next       = rv_reg;
        ra_next       = ra_reg;
        dst_next      = dst_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        issue         = 1'b0;
        cnt_up        = 1'b0;
        cnt_dn        = 1'b0;
        cnt_suit      = card_reg.suit;
        mem_we        = 1'b0;
        mem_waddr     = slot_addr;
        mem_wdata     = card_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next        = cdq_pkg::op_t'(s_tuser);
                    card_next.rank = s_tdata[3:0];
                    card_next.suit = s_tdata[5:4];
                    pcard_next     = '0;
                    status_next    = cdq_pkg::ST_OK;
                    off_next       = (cdq_pkg::op_t'(s_tuser) == cdq_pkg::OP_APPEND) ?
                                     held_reg : '0;
                    rv_next        = 1'b0;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC: begin
                case (op_reg)
                    cdq_pkg::OP_APPEND, cdq_pkg::OP_PUSH: begin
                        if (held_reg == CW'(CAPACITY)) begin
                            status_next = cdq_pkg::ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            held_next = held_reg + CW'(1);
                            cnt_up    = 1'b1;
                            if (op_reg == cdq_pkg::OP_PUSH) begin
                                front_next = front_dec;
                                mem_waddr  = front_dec;
                            end
                        end
                        state_next = S_RESP;
                    end
                    cdq_pkg::OP_POP: begin
                        if (held_reg == '0) begin
                            status_next = cdq_pkg::ST_EMPTY;
                            state_next  = S_RESP;
                        end else begin
                            issue      = 1'b1;
                            state_next = S_POPRD;
                        end
                    end
                    default: begin
                        state_next = S_SCAN;
                    end
                endcase
            end
            S_POPRD: begin
                pcard_next = mem_rdata;
                front_next = slot_addr;
                held_next  = held_reg - CW'(1);
                cnt_dn     = 1'b1;
                cnt_suit   = mem_rdata.suit;
                state_next = S_RESP;
            end
            S_SCAN: begin
                issue   = (off_reg < held_reg);
                rv_next = issue;
                ra_next = slot_addr;
                if (rv_reg && mem_rdata == card_reg) begin
                    dst_next = ra_reg;
                    if (issue) begin
                        state_next = S_SHIFT;
                    end else begin
                        held_next  = held_reg - CW'(1);
                        cnt_dn     = 1'b1;
                        state_next = S_RESP;
                    end
                end else if (!rv_reg && !issue) begin
                    status_next = cdq_pkg::ST_MISS;
                    state_next  = S_RESP;
                end
            end
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg;
                mem_wdata = mem_rdata;
                dst_next  = ra_reg;
                issue     = (off_reg < held_reg);
                rv_next   = issue;
                ra_next   = slot_addr;
                if (!issue) begin
                    held_next  = held_reg - CW'(1);
                    cnt_dn     = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = {7'b0, cnt_out[3], cnt_out[2], cnt_out[1], cnt_out[0],
                                     len_out, pcard_reg.suit, pcard_reg.rank};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (issue) begin
            off_next = off_reg + CW'(1);
        end
    end

    always_comb begin
        for (int j = 0; j < NS; j++) begin
            cnt_next[j] = cnt_reg[j];
            if (int'(cnt_suit) == j && j < SUIT_KINDS) begin
                if (cnt_up) begin
                    cnt_next[j] = cnt_reg[j] + CW'(1);
                end else if (cnt_dn && cnt_reg[j] != '0) begin
                    cnt_next[j] = cnt_reg[j] - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            front_reg    <= '0;
            held_reg     <= '0;
            rv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int j = 0; j < NS; j++) begin
                cnt_reg[j] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            held_reg     <= held_next;
            rv_reg       <= rv_next;
            m_tvalid_reg <= m_tvalid_next;
            for (int j = 0; j < NS; j++) begin
                cnt_reg[j] <= cnt_next[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        card_reg    <= card_next;
        pcard_reg   <= pcard_next;
        status_reg  <= status_next;
        off_reg     <= off_next;
        ra_reg      <= ra_next;
        dst_reg     <= dst_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== sv/cdq_checker.sv =====
// cdq_checker: port-level checks on the card deque, bound to the top level
// depends on cdq_pkg for the status codes
module cdq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // one op in flight: busy right after a beat is taken
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an op is in flight");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // popped card only reported on a good op
    a_popped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != cdq_pkg::ST_OK |-> m_tdata[5:0] == 6'd0)
        else $error("popped card set on a failed op");

    a_empty_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == cdq_pkg::ST_EMPTY |-> m_tdata[12:6] == 7'd0)
        else $error("pop on empty reported a non-zero length");

endmodule

bind card_deque_with_suit_counts cdq_checker u_cdq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
